[rtl/tkmm_pkg.sv]
// ----------------------------------------------------------------------------
// tkmm_pkg
// Types, sizes, codes and float32 helpers for the tiled key matrix multiply.
// ----------------------------------------------------------------------------
package tkmm_pkg;

    localparam int MAX_SIDE   = 64;
    localparam int N_FILES    = 4;     // power of two: file select is a bit slice
    localparam int MIN_KEY    = 8;

    localparam int FILE_WORDS = MAX_SIDE * MAX_SIDE;
    localparam int IDX_W      = 12;
    localparam int FID_W      = (N_FILES > 1) ? $clog2(N_FILES) : 1;
    localparam int MAT_DEPTH  = N_FILES * FILE_WORDS;
    localparam int MAT_AW     = $clog2(MAT_DEPTH);
    localparam int KEY_AW     = $clog2(FILE_WORDS);
    localparam int LOG_W      = 3;
    localparam logic [LOG_W-1:0] LOG_LO = LOG_W'($clog2(MIN_KEY));
    localparam logic [LOG_W-1:0] LOG_HI = LOG_W'($clog2(MAX_SIDE));
    localparam logic [LOG_W-1:0] MSL_RST = 3'd6;
    localparam logic [LOG_W-1:0] KSL_RST = 3'd3;

    localparam logic [31:0] FP_DEF_NAN = 32'hFFC00000;
    localparam logic [31:0] FP_QBIT    = 32'h00400000;

    typedef enum logic [1:0] {
        KIND_LOAD_MAT = 2'd0,
        KIND_LOAD_KEY = 2'd1,
        KIND_REQUEST  = 2'd2,
        KIND_NONE     = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_MATRIX_LOG2 = 1'b0,
        CFG_KEY_LOG2    = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_MNORM,
        ST_MRND,
        ST_AALIGN,
        ST_AADD,
        ST_ANORM,
        ST_ARND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]       kind;
        logic [31:0]      file_id;
        logic [IDX_W-1:0] index;
        logic [31:0]      value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] result_index;
        logic [31:0]      result_value;
        logic             status;
    } t_out_item;

    function automatic logic [LOG_W-1:0] clamp_log(input logic [LOG_W-1:0] v);
        logic [LOG_W-1:0] r;
        r = v;
        if (r > LOG_HI) r = LOG_HI;
        if (r < LOG_LO) r = LOG_LO;
        return r;
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        n = 5'd28;
        for (int i = 0; i < 28; i++) begin
            if (v[i]) n = 5'(27 - i);
        end
        return n;
    endfunction

    // sig: leading one at bit 26 (or below when be is at the bottom),
    // bits [2:0] plus stk are guard and sticky. Round to nearest even.
    function automatic logic [31:0] round_pack(input logic sgn,
                                               input logic signed [10:0] be,
                                               input logic [26:0] sig,
                                               input logic stk);
        logic [10:0] shamt;
        logic [9:0]  bee;
        logic [26:0] s;
        logic        st;
        logic [23:0] mant;
        logic        up;
        logic [33:0] tot;
        if (be < 11'sd1) begin
            shamt = 11'(11'sd1 - be);
            bee   = 10'd1;
        end else begin
            shamt = '0;
            bee   = be[9:0];
        end
        if (shamt > 11'd27) begin
            s  = '0;
            st = stk | (|sig);
        end else begin
            s  = sig >> shamt;
            st = stk | (|(sig & ((27'd1 << shamt) - 27'd1)));
        end
        mant = s[26:3];
        up   = s[2] & ((|s[1:0]) | st | s[3]);
        tot  = ({24'd0, bee - 10'd1} << 23) + {10'd0, mant} + {33'd0, up};
        if (tot >= 34'h07F800000) return {sgn, 31'h7F800000};
        return {sgn, tot[30:0]};
    endfunction

endpackage

[rtl/tiled_key_matrix_multiply_core.sv]
// ----------------------------------------------------------------------------
// tiled_key_matrix_multiply_core
// Key times each key-sized tile of a stored float32 matrix, one element per
// request, computed by a sequencer over two RAMs and a shared float unit.
// ----------------------------------------------------------------------------
// Loads leave the sequencer idle; a new beat can be taken the cycle after.
// A request runs K terms in turn (K = key side, 8..64): per term one RAM read,
// three multiply steps and four add steps on a single float datapath.
// A request with key larger than matrix skips the terms and goes from idle straight to the done state.
// Reset (synchronous, active low) idles the sequencer, drops the output beat
// and sets the sizes to 64 and 8; RAM contents are undefined until loaded.
module tiled_key_matrix_multiply_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tkmm_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tkmm_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [2:0]          i_cfg_data
);
    import tkmm_pkg::*;

    t_state r_state, n_state;
    logic [LOG_W-1:0] r_msl, r_ksl, sl, kl;
    logic [FID_W-1:0] r_fid;
    logic [IDX_W-1:0] r_idx;
    logic [5:0] r_t, r_u, r_c, r_k;
    logic [31:0] r_acc;
    logic        r_status;
    logic        r_out_valid;
    t_out_item   r_out;

    // multiply stage registers
    logic              r_pspec;
    logic [31:0]       r_pspecv;
    logic              r_psgn;
    logic signed [10:0] r_pexp;
    logic [47:0]       r_prod;
    logic [5:0]        r_plz;
    logic [31:0]       r_p;

    // add stage registers
    logic              r_aspec;
    logic [31:0]       r_aspecv;
    logic              r_asgn, r_asub;
    logic [7:0]        r_aexp;
    logic [26:0]       r_big, r_sml;
    logic [27:0]       r_sum;
    logic [4:0]        r_alz;

    logic accept, is_req, last_k, out_load;
    logic [IDX_W-1:0] wrapped, side_mask, key_mask;
    logic [IDX_W-1:0] key_raddr, mat_off;
    logic [31:0] key_rdata, mat_rdata;
    logic mat_we, key_we;

    assign sl = clamp_log(r_msl);
    assign kl = clamp_log(r_ksl);
    assign side_mask = IDX_W'((13'd1 << {sl, 1'b0}) - 13'd1);
    assign key_mask  = IDX_W'((13'd1 << {kl, 1'b0}) - 13'd1);
    assign wrapped   = i_in.index & side_mask;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign is_req      = (t_kind'(i_in.kind) == KIND_REQUEST);
    assign mat_we      = accept && (t_kind'(i_in.kind) == KIND_LOAD_MAT);
    assign key_we      = accept && (t_kind'(i_in.kind) == KIND_LOAD_KEY);
    assign last_k      = (r_k == 6'((7'd1 << kl) - 7'd1));
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    assign key_raddr = (IDX_W'(r_u) << kl) | IDX_W'(r_k);
    assign mat_off   = (IDX_W'(r_t + r_k) << sl) | IDX_W'(r_c);

    tkmm_ram #(.WIDTH(32), .DEPTH(MAT_DEPTH)) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr ({i_in.file_id[FID_W-1:0], wrapped}),
        .i_wdata (i_in.value),
        .i_raddr ({r_fid, mat_off}),
        .o_rdata (mat_rdata)
    );

    tkmm_ram #(.WIDTH(32), .DEPTH(FILE_WORDS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (KEY_AW'(i_in.index & key_mask)),
        .i_wdata (i_in.value),
        .i_raddr (KEY_AW'(key_raddr)),
        .o_rdata (key_rdata)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && is_req) n_state = (kl > sl) ? ST_DONE : ST_READ;
            end
            ST_READ:   n_state = ST_MUL;
            ST_MUL:    n_state = ST_MNORM;
            ST_MNORM:  n_state = ST_MRND;
            ST_MRND:   n_state = ST_AALIGN;
            ST_AALIGN: n_state = ST_AADD;
            ST_AADD:   n_state = ST_ANORM;
            ST_ANORM:  n_state = ST_ARND;
            ST_ARND:   n_state = last_k ? ST_DONE : ST_READ;
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msl <= MSL_RST;
            r_ksl <= KSL_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MATRIX_LOG2: r_msl <= i_cfg_data;
                CFG_KEY_LOG2:    r_ksl <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.result_index <= r_idx;
            r_out.result_value <= r_acc;
            r_out.status       <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // float datapath
    logic              ka_nan, kb_nan, ka_inf, kb_inf, ka_zero, kb_zero;
    logic [23:0]       sa, sb;
    logic [7:0]        ea, eb;
    logic [47:0]       pn;
    logic [31:0]       x, y, bigv, smlv;
    logic              x_nan, y_nan, x_inf, y_inf;
    logic [7:0]        ebig, esml, dexp;
    logic [26:0]       smx, shx;
    logic              sstk;
    logic [26:0]       asig;
    logic              astk;

    always_comb begin
        ka_nan  = (key_rdata[30:23] == 8'hFF) && (key_rdata[22:0] != '0);
        kb_nan  = (mat_rdata[30:23] == 8'hFF) && (mat_rdata[22:0] != '0);
        ka_inf  = (key_rdata[30:23] == 8'hFF) && (key_rdata[22:0] == '0);
        kb_inf  = (mat_rdata[30:23] == 8'hFF) && (mat_rdata[22:0] == '0);
        ka_zero = (key_rdata[30:0] == '0);
        kb_zero = (mat_rdata[30:0] == '0);
        sa = {key_rdata[30:23] != '0, key_rdata[22:0]};
        sb = {mat_rdata[30:23] != '0, mat_rdata[22:0]};
        ea = (key_rdata[30:23] == '0) ? 8'd1 : key_rdata[30:23];
        eb = (mat_rdata[30:23] == '0) ? 8'd1 : mat_rdata[30:23];

        pn = r_prod << r_plz;

        x = r_acc;
        y = r_p;
        x_nan = (x[30:23] == 8'hFF) && (x[22:0] != '0);
        y_nan = (y[30:23] == 8'hFF) && (y[22:0] != '0);
        x_inf = (x[30:23] == 8'hFF) && (x[22:0] == '0);
        y_inf = (y[30:23] == 8'hFF) && (y[22:0] == '0);
        if (x[30:0] >= y[30:0]) begin
            bigv = x;
            smlv = y;
        end else begin
            bigv = y;
            smlv = x;
        end
        ebig = (bigv[30:23] == '0) ? 8'd1 : bigv[30:23];
        esml = (smlv[30:23] == '0) ? 8'd1 : smlv[30:23];
        dexp = ebig - esml;
        smx  = {smlv[30:23] != '0, smlv[22:0], 3'b000};
        if (dexp >= 8'd27) begin
            shx  = '0;
            sstk = |smx;
        end else begin
            shx  = smx >> dexp;
            sstk = |(smx & ((27'd1 << dexp) - 27'd1));
        end

        // add result normalize: leading one brought to bit 26
        if (r_alz == 5'd0) begin
            asig = r_sum[27:1];
            astk = r_sum[0];
        end else begin
            asig = r_sum[26:0] << (r_alz - 5'd1);
            astk = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept && is_req) begin
                    r_fid    <= i_in.file_id[FID_W-1:0];
                    r_idx    <= wrapped;
                    r_u      <= 6'(wrapped >> sl) & 6'((7'd1 << kl) - 7'd1);
                    r_t      <= 6'(wrapped >> sl) & ~6'((7'd1 << kl) - 7'd1);
                    r_c      <= 6'(wrapped & IDX_W'((7'd1 << sl) - 7'd1));
                    r_k      <= '0;
                    r_acc    <= '0;
                    r_status <= (kl > sl);
                end
            end
            ST_MUL: begin
                r_psgn  <= key_rdata[31] ^ mat_rdata[31];
                r_pexp  <= 11'sd0 + $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
                r_prod  <= sa * sb;
                r_pspec <= 1'b1;
                if (ka_nan) begin
                    r_pspecv <= key_rdata | FP_QBIT;
                end else if (kb_nan) begin
                    r_pspecv <= mat_rdata | FP_QBIT;
                end else if ((ka_inf && kb_zero) || (kb_inf && ka_zero)) begin
                    r_pspecv <= FP_DEF_NAN;
                end else if (ka_inf || kb_inf) begin
                    r_pspecv <= {key_rdata[31] ^ mat_rdata[31], 31'h7F800000};
                end else begin
                    r_pspec  <= 1'b0;
                    r_pspecv <= '0;
                end
            end
            ST_MNORM: r_plz <= lzc48(r_prod);
            ST_MRND: begin
                if (r_pspec) r_p <= r_pspecv;
                else if (r_prod == '0) r_p <= {r_psgn, 31'd0};
                else r_p <= round_pack(r_psgn, r_pexp - $signed({5'd0, r_plz}),
                                       pn[47:21], |pn[20:0]);
            end
            ST_AALIGN: begin
                r_aspec <= 1'b1;
                if (x_nan) begin
                    r_aspecv <= x | FP_QBIT;
                end else if (y_nan) begin
                    r_aspecv <= y | FP_QBIT;
                end else if (x_inf && y_inf && (x[31] != y[31])) begin
                    r_aspecv <= FP_DEF_NAN;
                end else if (x_inf) begin
                    r_aspecv <= x;
                end else if (y_inf) begin
                    r_aspecv <= y;
                end else begin
                    r_aspec  <= 1'b0;
                    r_aspecv <= '0;
                end
                r_asgn <= bigv[31];
                r_asub <= x[31] ^ y[31];
                r_aexp <= ebig;
                r_big  <= {bigv[30:23] != '0, bigv[22:0], 3'b000};
                r_sml  <= {shx[26:1], shx[0] | sstk};
            end
            ST_AADD: begin
                r_sum <= r_asub ? ({1'b0, r_big} - {1'b0, r_sml})
                                : ({1'b0, r_big} + {1'b0, r_sml});
            end
            ST_ANORM: r_alz <= lzc28(r_sum);
            ST_ARND: begin
                if (r_aspec) r_acc <= r_aspecv;
                else if (r_sum == '0) r_acc <= {r_asub ? 1'b0 : r_asgn, 31'd0};
                else r_acc <= round_pack(r_asgn,
                                         $signed({3'b000, r_aexp}) + 11'sd1
                                         - $signed({6'd0, r_alz}),
                                         asig, astk);
                r_k <= r_k + 6'd1;
            end
            default: ;
        endcase
    end
endmodule

[rtl/tkmm_ram.sv]
// ----------------------------------------------------------------------------
// tkmm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tkmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/tkmm_checker.sv]
// ----------------------------------------------------------------------------
// tkmm_checker
// Port-level checks for the tiled key matrix multiply core.
// ----------------------------------------------------------------------------
module tkmm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input tkmm_pkg::t_in_item  i_in,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input tkmm_pkg::t_out_item o_out
);
    import tkmm_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    // error status carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status |-> o_out.result_value == 32'd0)
        else $error("error beat with nonzero value");

    // a request makes the block busy in the cycle after its acceptance
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in.kind == KIND_REQUEST) |=> !o_in_ready)
        else $error("input ready right after a request");

    // reset drops the result beat
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");
endmodule

bind tiled_key_matrix_multiply_core tkmm_checker u_tkmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
